FILE: sv/mof_pkg.sv
// Shared constants, opcodes and types of the MAC / vendor prefix filter.
package mof_pkg;

    localparam int MAC_ENTRIES    = 16;
    localparam int PREFIX_ENTRIES = 16;
    localparam int CELL_COUNT     = (MAC_ENTRIES > PREFIX_ENTRIES) ? MAC_ENTRIES
                                                                   : PREFIX_ENTRIES;

    localparam int OP_W     = 3;
    localparam int ADDR_W   = 48;
    localparam int PREFIX_W = 24;

    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_WIFI   = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD_BLE    = 3'd2;
    localparam logic [OP_W-1:0] OP_ADD_PREFIX = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY_WIFI = 3'd4;
    localparam logic [OP_W-1:0] OP_QUERY_BLE  = 3'd5;

    // per-cell compare hits, OR'ed down the chain
    typedef struct packed {
        logic wifi_a;
        logic wifi_b;
        logic ble_a;
        logic pfx_a;
        logic pfx_b;
        logic pfx_p;
    } hit_t;

    // one flag per table: enables, write strobes, free-slot tokens
    typedef struct packed {
        logic wifi;
        logic ble;
        logic pfx;
    } tbl_t;

endpackage

FILE: sv/mac_oui_match_filter_top.sv
// Top level of the MAC / vendor prefix filter: control, cell chain and result register.
//
// Keeps de-duplicated WiFi MAC, BLE MAC and vendor prefix tables in a row of
// CELL_COUNT cells, each holding one entry of every table. At acceptance all cells
// compare the incoming addresses against their entries in parallel and register the
// hits; then, in the decode state, the hits are OR'ed down the cell chain, an add
// writes the first free cell and the result is loaded into the output register. One
// word is in work at a time, so a new word is taken only once the last has left the
// decode state; a waiting result stalls the word behind it in that state. Clear
// empties all tables.
module mac_oui_match_filter_top
    import mof_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_opcode,
    input  logic [ADDR_W-1:0]   s_addr_a,
    input  logic                s_addr_a_present,
    input  logic [ADDR_W-1:0]   s_addr_b,
    input  logic                s_addr_b_present,
    input  logic [PREFIX_W-1:0] s_prefix,
    input  logic                s_prefix_present,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_accepted,
    output logic                m_known,
    output logic                m_table_full
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DEC  = 1'b1;

    logic                state_reg;
    logic [OP_W-1:0]     op_reg;
    logic [ADDR_W-1:0]   addr_a_reg;
    logic                a_ok_reg;
    logic                b_ok_reg;
    logic [PREFIX_W-1:0] prefix_reg;
    logic                p_ok_reg;

    logic                m_valid_reg;
    logic                acc_reg;
    logic                known_reg;
    logic                full_reg;

    logic                accept;
    logic                dec_fire;
    logic                clr;
    tbl_t                wr_req;
    tbl_t                wr;
    logic                acc_next;
    logic                known_next;
    logic                full_next;
    hit_t                hit;
    tbl_t                tbl_full;

    hit_t                hit_chain [CELL_COUNT+1];
    tbl_t                tok_chain [CELL_COUNT+1];

    assign s_ready      = (state_reg == ST_IDLE);
    assign accept       = s_valid && s_ready;
    assign dec_fire     = (state_reg == ST_DEC) && (!m_valid_reg || m_ready);
    assign m_valid      = m_valid_reg;
    assign m_accepted   = acc_reg;
    assign m_known      = known_reg;
    assign m_table_full = full_reg;

    assign hit_chain[0] = '0;
    assign tok_chain[0] = '1;
    assign hit          = hit_chain[CELL_COUNT];
    // token still alive past the last usable cell: every slot is taken
    assign tbl_full.wifi = tok_chain[MAC_ENTRIES].wifi;
    assign tbl_full.ble  = tok_chain[MAC_ENTRIES].ble;
    assign tbl_full.pfx  = tok_chain[PREFIX_ENTRIES].pfx;

    genvar i;
    generate
        for (i = 0; i < CELL_COUNT; i++) begin : g_cell
            localparam logic MAC_ON = (i < MAC_ENTRIES);
            localparam logic PFX_ON = (i < PREFIX_ENTRIES);
            tbl_t cell_en;
            assign cell_en.wifi = MAC_ON;
            assign cell_en.ble  = MAC_ON;
            assign cell_en.pfx  = PFX_ON;

            mof_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .enable_i (cell_en),
                .cap_i    (accept),
                .addr_a_i (s_addr_a),
                .addr_b_i (s_addr_b),
                .prefix_i (s_prefix),
                .clr_i    (clr),
                .wr_i     (wr),
                .wr_mac_i (addr_a_reg),
                .wr_pfx_i (prefix_reg),
                .hit_i    (hit_chain[i]),
                .hit_o    (hit_chain[i+1]),
                .tok_i    (tok_chain[i]),
                .tok_o    (tok_chain[i+1])
            );
        end
    endgenerate

    always_comb begin
        acc_next   = 1'b0;
        known_next = 1'b0;
        full_next  = 1'b0;
        wr_req     = '0;
        unique case (op_reg)
            OP_CLEAR: begin
                acc_next = 1'b1;
            end
            OP_ADD_WIFI: begin
                if (a_ok_reg) begin
                    if (hit.wifi_a) begin
                        acc_next = 1'b1;
                    end else if (tbl_full.wifi) begin
                        full_next = 1'b1;
                    end else begin
                        acc_next    = 1'b1;
                        wr_req.wifi = 1'b1;
                    end
                end
            end
            OP_ADD_BLE: begin
                if (a_ok_reg) begin
                    if (hit.ble_a) begin
                        acc_next = 1'b1;
                    end else if (tbl_full.ble) begin
                        full_next = 1'b1;
                    end else begin
                        acc_next   = 1'b1;
                        wr_req.ble = 1'b1;
                    end
                end
            end
            OP_ADD_PREFIX: begin
                if (p_ok_reg) begin
                    if (hit.pfx_p) begin
                        acc_next = 1'b1;
                    end else if (tbl_full.pfx) begin
                        full_next = 1'b1;
                    end else begin
                        acc_next   = 1'b1;
                        wr_req.pfx = 1'b1;
                    end
                end
            end
            OP_QUERY_WIFI: begin
                known_next = (a_ok_reg && (hit.wifi_a || hit.pfx_a))
                          || (b_ok_reg && (hit.wifi_b || hit.pfx_b));
            end
            OP_QUERY_BLE: begin
                known_next = a_ok_reg && (hit.ble_a || hit.pfx_a);
            end
            default: begin
            end
        endcase
    end

    assign wr.wifi = wr_req.wifi && dec_fire;
    assign wr.ble  = wr_req.ble  && dec_fire;
    assign wr.pfx  = wr_req.pfx  && dec_fire;
    assign clr     = dec_fire && (op_reg == OP_CLEAR);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= ST_DEC;
            end else if (dec_fire) begin
                state_reg <= ST_IDLE;
            end
            if (dec_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= s_opcode;
            addr_a_reg <= s_addr_a;
            a_ok_reg   <= s_addr_a_present;
            b_ok_reg   <= s_addr_b_present;
            prefix_reg <= s_prefix;
            p_ok_reg   <= s_prefix_present;
        end
        if (dec_fire) begin
            acc_reg   <= acc_next;
            known_reg <= known_next;
            full_reg  <= full_next;
        end
    end

endmodule

FILE: sv/mof_cell.sv
// One filter cell: holds one WiFi, one BLE and one prefix entry and compares them.
module mof_cell
    import mof_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  tbl_t                enable_i,
    input  logic                cap_i,
    input  logic [ADDR_W-1:0]   addr_a_i,
    input  logic [ADDR_W-1:0]   addr_b_i,
    input  logic [PREFIX_W-1:0] prefix_i,
    input  logic                clr_i,
    input  tbl_t                wr_i,
    input  logic [ADDR_W-1:0]   wr_mac_i,
    input  logic [PREFIX_W-1:0] wr_pfx_i,
    input  hit_t                hit_i,
    output hit_t                hit_o,
    input  tbl_t                tok_i,
    output tbl_t                tok_o
);

    tbl_t                valid_reg;
    tbl_t                take;
    hit_t                hit_reg;
    hit_t                hit_next;
    logic [ADDR_W-1:0]   wifi_reg;
    logic [ADDR_W-1:0]   ble_reg;
    logic [PREFIX_W-1:0] pfx_reg;

    // first empty cell in the chain takes the write
    assign take.wifi  = tok_i.wifi & ~valid_reg.wifi & enable_i.wifi;
    assign take.ble   = tok_i.ble  & ~valid_reg.ble  & enable_i.ble;
    assign take.pfx   = tok_i.pfx  & ~valid_reg.pfx  & enable_i.pfx;
    assign tok_o.wifi = tok_i.wifi & valid_reg.wifi;
    assign tok_o.ble  = tok_i.ble  & valid_reg.ble;
    assign tok_o.pfx  = tok_i.pfx  & valid_reg.pfx;

    always_comb begin
        hit_next.wifi_a = valid_reg.wifi && (wifi_reg == addr_a_i);
        hit_next.wifi_b = valid_reg.wifi && (wifi_reg == addr_b_i);
        hit_next.ble_a  = valid_reg.ble  && (ble_reg == addr_a_i);
        hit_next.pfx_a  = valid_reg.pfx  && (pfx_reg == addr_a_i[ADDR_W-1 -: PREFIX_W]);
        hit_next.pfx_b  = valid_reg.pfx  && (pfx_reg == addr_b_i[ADDR_W-1 -: PREFIX_W]);
        hit_next.pfx_p  = valid_reg.pfx  && (pfx_reg == prefix_i);
    end

    assign hit_o = hit_i | hit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || clr_i) begin
            valid_reg <= '0;
        end else begin
            if (wr_i.wifi && take.wifi) valid_reg.wifi <= 1'b1;
            if (wr_i.ble && take.ble)   valid_reg.ble  <= 1'b1;
            if (wr_i.pfx && take.pfx)   valid_reg.pfx  <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_i.wifi && take.wifi) wifi_reg <= wr_mac_i;
        if (wr_i.ble && take.ble)   ble_reg  <= wr_mac_i;
        if (wr_i.pfx && take.pfx)   pfx_reg  <= wr_pfx_i;
        if (cap_i)                  hit_reg  <= hit_next;
    end

endmodule

FILE: sim/mac_oui_match_filter_check.sv
`timescale 1ns / 100ps
// Checker for the MAC / vendor prefix filter: tracks the three tables and scores each result word.
module mac_oui_match_filter_check
    import mof_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [OP_W-1:0]     s_opcode,
    input  logic [ADDR_W-1:0]   s_addr_a,
    input  logic                s_addr_a_present,
    input  logic [ADDR_W-1:0]   s_addr_b,
    input  logic                s_addr_b_present,
    input  logic [PREFIX_W-1:0] s_prefix,
    input  logic                s_prefix_present,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic                m_accepted,
    input  logic                m_known,
    input  logic                m_table_full,
    output int                  mismatches,
    output int                  words_outstanding,
    output int                  results_checked,
    output int                  full_refusals,
    output int                  query_hits
);

    typedef struct packed {
        logic accepted;
        logic known;
        logic table_full;
    } verdict_t;

    logic [ADDR_W-1:0]   wifi_tab [MAC_ENTRIES];
    logic [ADDR_W-1:0]   ble_tab  [MAC_ENTRIES];
    logic [PREFIX_W-1:0] oui_tab  [PREFIX_ENTRIES];
    int wifi_count = 0;
    int ble_count  = 0;
    int oui_count  = 0;

    verdict_t awaited_verdicts [$];
    verdict_t want;
    int fail_count = 0;
    int open_count = 0;
    int done_count = 0;
    int full_count = 0;
    int hit_count  = 0;

    assign mismatches        = fail_count;
    assign words_outstanding = open_count;
    assign results_checked   = done_count;
    assign full_refusals     = full_count;
    assign query_hits        = hit_count;

    function automatic logic in_wifi(logic [ADDR_W-1:0] key);
        int i;
        for (i = 0; i < wifi_count; i++)
            if (wifi_tab[i] == key) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic in_ble(logic [ADDR_W-1:0] key);
        int i;
        for (i = 0; i < ble_count; i++)
            if (ble_tab[i] == key) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic in_oui(logic [PREFIX_W-1:0] key);
        int i;
        for (i = 0; i < oui_count; i++)
            if (oui_tab[i] == key) return 1'b1;
        return 1'b0;
    endfunction

    // applies one word to the shadow tables and returns the result it must give
    function automatic verdict_t filter_outcome(
        logic [OP_W-1:0] op,
        logic [ADDR_W-1:0] a, logic a_ok,
        logic [ADDR_W-1:0] b, logic b_ok,
        logic [PREFIX_W-1:0] p, logic p_ok
    );
        verdict_t v;
        v = '0;
        case (op)
            OP_CLEAR: begin
                wifi_count = 0;
                ble_count  = 0;
                oui_count  = 0;
                v.accepted = 1'b1;
            end
            OP_ADD_WIFI: begin
                if (a_ok) begin
                    if (in_wifi(a)) begin
                        v.accepted = 1'b1;
                    end else if (wifi_count >= MAC_ENTRIES) begin
                        v.table_full = 1'b1;
                    end else begin
                        wifi_tab[wifi_count] = a;
                        wifi_count++;
                        v.accepted = 1'b1;
                    end
                end
            end
            OP_ADD_BLE: begin
                if (a_ok) begin
                    if (in_ble(a)) begin
                        v.accepted = 1'b1;
                    end else if (ble_count >= MAC_ENTRIES) begin
                        v.table_full = 1'b1;
                    end else begin
                        ble_tab[ble_count] = a;
                        ble_count++;
                        v.accepted = 1'b1;
                    end
                end
            end
            OP_ADD_PREFIX: begin
                if (p_ok) begin
                    if (in_oui(p)) begin
                        v.accepted = 1'b1;
                    end else if (oui_count >= PREFIX_ENTRIES) begin
                        v.table_full = 1'b1;
                    end else begin
                        oui_tab[oui_count] = p;
                        oui_count++;
                        v.accepted = 1'b1;
                    end
                end
            end
            OP_QUERY_WIFI: begin
                v.known = (a_ok && (in_wifi(a) || in_oui(a[ADDR_W-1 -: PREFIX_W]))) ||
                          (b_ok && (in_wifi(b) || in_oui(b[ADDR_W-1 -: PREFIX_W])));
            end
            OP_QUERY_BLE: begin
                v.known = a_ok && (in_ble(a) || in_oui(a[ADDR_W-1 -: PREFIX_W]));
            end
            default: ;
        endcase
        return v;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            wifi_count = 0;
            ble_count  = 0;
            oui_count  = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_verdicts.size() == 0) begin
                    $error("result word with nothing outstanding: accepted=%0b known=%0b full=%0b",
                           m_accepted, m_known, m_table_full);
                    fail_count++;
                end else begin
                    want = awaited_verdicts.pop_front();
                    open_count--;
                    done_count++;
                    if (m_accepted !== want.accepted) begin
                        $error("accepted: expected %0b, got %0b", want.accepted, m_accepted);
                        fail_count++;
                    end
                    if (m_known !== want.known) begin
                        $error("known: expected %0b, got %0b", want.known, m_known);
                        fail_count++;
                    end
                    if (m_table_full !== want.table_full) begin
                        $error("table_full: expected %0b, got %0b",
                               want.table_full, m_table_full);
                        fail_count++;
                    end
                    if (want.table_full) full_count++;
                    if (want.known) hit_count++;
                end
            end
            if (s_valid && s_ready) begin
                awaited_verdicts.insert(awaited_verdicts.size(), filter_outcome(s_opcode,
                    s_addr_a, s_addr_a_present, s_addr_b, s_addr_b_present,
                    s_prefix, s_prefix_present));
                open_count++;
            end
        end
    end

endmodule

FILE: sim/mac_oui_match_filter_top_test.sv
`timescale 1ns / 100ps
// Testbench top for the MAC / vendor prefix filter: clock, reset, stimulus and verdict.
module mac_oui_match_filter_top_test;
    import mof_pkg::*;

    localparam logic [OP_W-1:0] OP_RESERVED_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RESERVED_7 = 3'd7;
    localparam int RANDOM_WORDS = 1200;
    localparam int POOL_N       = 24;
    localparam int LONG_HOLD    = 300;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [OP_W-1:0]     s_opcode;
    logic [ADDR_W-1:0]   s_addr_a;
    logic                s_addr_a_present;
    logic [ADDR_W-1:0]   s_addr_b;
    logic                s_addr_b_present;
    logic [PREFIX_W-1:0] s_prefix;
    logic                s_prefix_present;
    logic                m_valid;
    logic                m_ready;
    logic                m_accepted;
    logic                m_known;
    logic                m_table_full;

    int mismatches;
    int words_outstanding;
    int results_checked;
    int full_refusals;
    int query_hits;

    int words_sent = 0;

    logic [ADDR_W-1:0]   wifi_pool [POOL_N];
    logic [ADDR_W-1:0]   ble_pool  [POOL_N];
    logic [PREFIX_W-1:0] oui_pool  [POOL_N];

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    mac_oui_match_filter_top uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_addr_a         (s_addr_a),
        .s_addr_a_present (s_addr_a_present),
        .s_addr_b         (s_addr_b),
        .s_addr_b_present (s_addr_b_present),
        .s_prefix         (s_prefix),
        .s_prefix_present (s_prefix_present),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_accepted       (m_accepted),
        .m_known          (m_known),
        .m_table_full     (m_table_full)
    );

    mac_oui_match_filter_check filter_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_addr_a          (s_addr_a),
        .s_addr_a_present  (s_addr_a_present),
        .s_addr_b          (s_addr_b),
        .s_addr_b_present  (s_addr_b_present),
        .s_prefix          (s_prefix),
        .s_prefix_present  (s_prefix_present),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_accepted        (m_accepted),
        .m_known           (m_known),
        .m_table_full      (m_table_full),
        .mismatches        (mismatches),
        .words_outstanding (words_outstanding),
        .results_checked   (results_checked),
        .full_refusals     (full_refusals),
        .query_hits        (query_hits)
    );

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[ADDR_W-1:0];
    endfunction

    function automatic logic [PREFIX_W-1:0] rand_prefix();
        logic [31:0] v;
        v = $urandom;
        return v[PREFIX_W-1:0];
    endfunction

    // half pool addresses so tables fill and repeat; some hit only through a prefix
    function automatic logic [ADDR_W-1:0] pick_mac(bit from_ble);
        logic [ADDR_W-1:0] low;
        low = rand_addr();
        case ($urandom_range(0, 3))
            0, 1:    return from_ble ? ble_pool[$urandom_range(0, POOL_N-1)]
                                     : wifi_pool[$urandom_range(0, POOL_N-1)];
            2:       return {oui_pool[$urandom_range(0, POOL_N-1)], low[ADDR_W-PREFIX_W-1:0]};
            default: return low;
        endcase
    endfunction

    function automatic logic pick_present();
        return $urandom_range(0, 9) != 0;
    endfunction

    task automatic send_word(
        input logic [OP_W-1:0] op,
        input logic [ADDR_W-1:0] a, input logic a_ok,
        input logic [ADDR_W-1:0] b, input logic b_ok,
        input logic [PREFIX_W-1:0] p, input logic p_ok
    );
        int gap;
        // every third block of 100 words goes back to back
        gap = ((words_sent / 100) % 3 == 1) ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_opcode         <= op;
        s_addr_a         <= a;
        s_addr_a_present <= a_ok;
        s_addr_b         <= b;
        s_addr_b_present <= b_ok;
        s_prefix         <= p;
        s_prefix_present <= p_ok;
        do @(posedge aclk); while (!(s_valid && s_ready));
        words_sent++;
    endtask

    task automatic send_random_word();
        logic [OP_W-1:0]     op;
        logic [ADDR_W-1:0]   a;
        logic [ADDR_W-1:0]   b;
        logic [PREFIX_W-1:0] p;
        int r;
        r = $urandom_range(0, 299);
        if (r < 2) begin
            op = OP_CLEAR;
        end else if (r < 6) begin
            op = r[0] ? OP_RESERVED_6 : OP_RESERVED_7;
        end else begin
            case (r % 5)
                0:       op = OP_ADD_WIFI;
                1:       op = OP_ADD_BLE;
                2:       op = OP_ADD_PREFIX;
                3:       op = OP_QUERY_WIFI;
                default: op = OP_QUERY_BLE;
            endcase
        end
        a = rand_addr();
        b = rand_addr();
        p = rand_prefix();
        if (op == OP_ADD_WIFI || op == OP_QUERY_WIFI) a = pick_mac(1'b0);
        if (op == OP_ADD_BLE || op == OP_QUERY_BLE) a = pick_mac(1'b1);
        if (op == OP_QUERY_WIFI) b = pick_mac(1'b0);
        if (op == OP_ADD_PREFIX && $urandom_range(0, 9) < 7)
            p = oui_pool[$urandom_range(0, POOL_N-1)];
        send_word(op, a, pick_present(), b, pick_present(), p, pick_present());
    endtask

    // result side: random stalls, quiet stretches, and one long hold-off
    initial begin
        int gap;
        int taken;
        taken = 0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (taken == 500)
                gap = LONG_HOLD;
            else if ((taken / 120) % 3 == 2)
                gap = 0;
            else
                gap = $urandom_range(0, 18);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            taken++;
        end
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int i;
        logic [ADDR_W-1:0] low;
        aresetn          <= 1'b0;
        s_valid          <= 1'b0;
        s_opcode         <= OP_CLEAR;
        s_addr_a         <= '0;
        s_addr_a_present <= 1'b0;
        s_addr_b         <= '0;
        s_addr_b_present <= 1'b0;
        s_prefix         <= '0;
        s_prefix_present <= 1'b0;
        for (i = 0; i < POOL_N; i++) begin
            oui_pool[i]  = rand_prefix();
            wifi_pool[i] = rand_addr();
            ble_pool[i]  = rand_addr();
        end
        // half of the MAC pools sit under a known vendor prefix
        for (i = 0; i < POOL_N; i += 2) begin
            low = rand_addr();
            wifi_pool[i] = {oui_pool[$urandom_range(0, POOL_N-1)], low[ADDR_W-PREFIX_W-1:0]};
            low = rand_addr();
            ble_pool[i]  = {oui_pool[$urandom_range(0, POOL_N-1)], low[ADDR_W-PREFIX_W-1:0]};
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, absent operands, duplicates, prefix hits, unused opcodes
        send_word(OP_CLEAR,      '1, 1'b1, '1, 1'b1, '1, 1'b1);
        send_word(OP_ADD_WIFI,   '1, 1'b0, '1, 1'b1, '1, 1'b1);
        send_word(OP_ADD_BLE,    '0, 1'b0, '0, 1'b0, '0, 1'b0);
        send_word(OP_ADD_PREFIX, '1, 1'b1, '1, 1'b1, '1, 1'b0);
        send_word(OP_ADD_WIFI,   '1, 1'b1, '0, 1'b0, '0, 1'b0);
        send_word(OP_ADD_WIFI,   '0, 1'b1, '1, 1'b1, '1, 1'b1);
        send_word(OP_ADD_WIFI,   '1, 1'b1, '0, 1'b0, '0, 1'b0);
        send_word(OP_ADD_BLE,    '1, 1'b1, '0, 1'b0, '0, 1'b0);
        send_word(OP_ADD_PREFIX, '0, 1'b0, '0, 1'b0, '1, 1'b1);
        send_word(OP_ADD_PREFIX, '1, 1'b1, '1, 1'b1, '0, 1'b1);
        send_word(OP_QUERY_WIFI, '1, 1'b1, '1, 1'b0, '0, 1'b0);
        send_word(OP_QUERY_WIFI, '1, 1'b0, '0, 1'b1, '0, 1'b0);
        send_word(OP_QUERY_WIFI, '1, 1'b0, '0, 1'b0, '1, 1'b1);
        send_word(OP_QUERY_WIFI, 48'h123456_ABCDEF, 1'b1, 48'h000000_ABCDEF, 1'b1, '0, 1'b0);
        send_word(OP_QUERY_BLE,  48'hFFFFFF_000001, 1'b1, '0, 1'b0, '0, 1'b0);
        send_word(OP_QUERY_BLE,  '1, 1'b0, '1, 1'b1, '1, 1'b1);
        send_word(OP_QUERY_BLE,  48'h5A5A5A_5A5A5A, 1'b1, '0, 1'b0, '0, 1'b0);
        send_word(OP_RESERVED_6, '1, 1'b1, '1, 1'b1, '1, 1'b1);
        send_word(OP_RESERVED_7, '1, 1'b1, '1, 1'b1, '1, 1'b1);
        send_word(OP_QUERY_WIFI, '0, 1'b1, '0, 1'b0, '0, 1'b0);
        send_word(OP_CLEAR,      '0, 1'b0, '0, 1'b0, '0, 1'b0);
        send_word(OP_QUERY_WIFI, '1, 1'b1, '0, 1'b1, '0, 1'b0);

        for (i = 0; i < RANDOM_WORDS; i++)
            send_random_word();
        s_valid <= 1'b0;

        @(posedge aclk);
        while (words_outstanding != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Sent %0d words, checked %0d results.", words_sent, results_checked);
        $display("Query hits: %0d, adds refused on a full table: %0d.",
                 query_hits, full_refusals);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
